// File: sv/c8eu_pkg.sv
// ----------------------------------------------------------------------------
// c8eu_pkg - shared types and constants of the CHIP-8 register execute unit
// Operation codes, status codes, widths and the execute-stage interface
// structs used by the core, the ALU and the checker.
// ----------------------------------------------------------------------------
package c8eu_pkg;

  localparam int STACK_ENTRIES = 16;
  localparam int REG_COUNT     = 16;

  localparam int REG_IDX_W   = $clog2(REG_COUNT);
  localparam int STACK_IDX_W = (STACK_ENTRIES > 2) ? $clog2(STACK_ENTRIES) : 1;
  localparam int LEVEL_W     = $clog2(STACK_ENTRIES + 1);

  localparam logic [REG_IDX_W-1:0] FLAG_REG  = 4'hF;
  localparam logic [7:0]           BYTE_MASK = 8'hFF;
  localparam logic [7:0]           MSB_MASK  = 8'h80;

  typedef enum logic [4:0] {
    OP_JMP   = 5'd0,
    OP_CALL  = 5'd1,
    OP_RET   = 5'd2,
    OP_SEB   = 5'd3,
    OP_SNEB  = 5'd4,
    OP_SER   = 5'd5,
    OP_SNER  = 5'd6,
    OP_LDB   = 5'd7,
    OP_ADDB  = 5'd8,
    OP_LDR   = 5'd9,
    OP_OR    = 5'd10,
    OP_AND   = 5'd11,
    OP_XOR   = 5'd12,
    OP_ADDR  = 5'd13,
    OP_SUB   = 5'd14,
    OP_SHR   = 5'd15,
    OP_SUBN  = 5'd16,
    OP_SHL   = 5'd17,
    OP_LDI   = 5'd18,
    OP_JPV0  = 5'd19,
    OP_VDT   = 5'd20,
    OP_DTV   = 5'd21,
    OP_STV   = 5'd22,
    OP_IADD  = 5'd23,
    OP_DIGIT = 5'd24
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic [4:0]           mode;
    logic [REG_IDX_W-1:0] reg_x;
    logic [7:0]           imm;
    logic [11:0]          addr;
    logic [7:0]           vx;
    logic [7:0]           vy;
    logic [7:0]           v0;
    logic [7:0]           vf;
    logic [15:0]          pc;
    logic [15:0]          index;
    logic [7:0]           delay;
    logic [7:0]           sound;
    logic [LEVEL_W-1:0]   level;
    logic [15:0]          tos;
  } alu_in_t;

  typedef struct packed {
    logic [15:0] pc;
    logic [15:0] index;
    logic [7:0]  delay;
    logic [7:0]  sound;
    logic        gp_we;
    logic [7:0]  gp_wdata;
    logic        vf_we;
    logic [7:0]  vf_wdata;
    logic        push;
    logic        pop;
    status_t     status;
    logic [7:0]  dest_value;
    logic [7:0]  flag_value;
  } alu_out_t;

endpackage

// File: sv/c8eu_alu.sv
// ----------------------------------------------------------------------------
// c8eu_alu - execute logic of the CHIP-8 register execute unit
// Combinational next-state computation for one decoded operation: PC, I,
// timers, register writes, stack push/pop and status.
// ----------------------------------------------------------------------------
module c8eu_alu (
  input  c8eu_pkg::alu_in_t  alu_i,
  output c8eu_pkg::alu_out_t alu_o
);
  import c8eu_pkg::*;

  logic [8:0] sum9;
  logic [7:0] res;
  logic       flag;
  logic       flagged;
  logic       wr;
  logic [7:0] wval;
  logic       skip;

  assign sum9 = {1'b0, alu_i.vx} + {1'b0, alu_i.vy};

  always_comb begin
    res           = 8'h00;
    flag          = 1'b0;
    flagged       = 1'b0;
    wr            = 1'b0;
    wval          = 8'h00;
    skip          = 1'b0;
    alu_o.pc      = alu_i.pc;
    alu_o.index   = alu_i.index;
    alu_o.delay   = alu_i.delay;
    alu_o.sound   = alu_i.sound;
    alu_o.push    = 1'b0;
    alu_o.pop     = 1'b0;
    alu_o.status  = ST_OK;

    unique case (mode_t'(alu_i.mode))
      OP_JMP:  alu_o.pc = {4'h0, alu_i.addr};
      OP_CALL: begin
        if (alu_i.level >= LEVEL_W'(STACK_ENTRIES)) begin
          alu_o.status = ST_OVERFLOW;
        end else begin
          alu_o.push = 1'b1;
          alu_o.pc   = {4'h0, alu_i.addr};
        end
      end
      OP_RET: begin
        if (alu_i.level == '0) begin
          alu_o.status = ST_UNDERFLOW;
        end else begin
          alu_o.pop = 1'b1;
          alu_o.pc  = alu_i.tos;
        end
      end
      OP_SEB:  skip = (alu_i.vx == alu_i.imm);
      OP_SNEB: skip = (alu_i.vx != alu_i.imm);
      OP_SER:  skip = (alu_i.vx == alu_i.vy);
      OP_SNER: skip = (alu_i.vx != alu_i.vy);
      OP_LDB: begin
        wr   = 1'b1;
        wval = alu_i.imm;
      end
      OP_ADDB: begin
        wr   = 1'b1;
        wval = alu_i.vx + alu_i.imm;
      end
      OP_LDR: begin
        wr   = 1'b1;
        wval = alu_i.vy;
      end
      OP_OR: begin
        wr   = 1'b1;
        wval = alu_i.vx | alu_i.vy;
      end
      OP_AND: begin
        wr   = 1'b1;
        wval = alu_i.vx & alu_i.vy;
      end
      OP_XOR: begin
        wr   = 1'b1;
        wval = alu_i.vx ^ alu_i.vy;
      end
      OP_ADDR: begin
        flagged = 1'b1;
        res     = sum9[7:0];
        flag    = (sum9 > {1'b0, BYTE_MASK});
      end
      OP_SUB: begin
        flagged = 1'b1;
        res     = alu_i.vx - alu_i.vy;
        flag    = (alu_i.vx > alu_i.vy);
      end
      OP_SHR: begin
        flagged = 1'b1;
        res     = {1'b0, alu_i.vx[7:1]};
        flag    = alu_i.vx[0];
      end
      OP_SUBN: begin
        flagged = 1'b1;
        res     = alu_i.vy - alu_i.vx;
        flag    = (alu_i.vy > alu_i.vx);
      end
      OP_SHL: begin
        flagged = 1'b1;
        res     = {alu_i.vx[6:0], 1'b0};
        flag    = |(alu_i.vx & MSB_MASK);
      end
      OP_LDI:  alu_o.index = {4'h0, alu_i.addr};
      OP_JPV0: alu_o.pc    = {4'h0, alu_i.addr} + {8'h00, alu_i.v0};
      OP_VDT: begin
        wr   = 1'b1;
        wval = alu_i.delay;
      end
      OP_DTV:  alu_o.delay = alu_i.vx;
      OP_STV:  alu_o.sound = alu_i.vx;
      OP_IADD: alu_o.index = alu_i.index + {8'h00, alu_i.vx};
      // digit sprites are 5 bytes each: I = Vx * 5
      OP_DIGIT: alu_o.index = {6'h00, alu_i.vx, 2'b00} + {8'h00, alu_i.vx};
      default: ;
    endcase

    if (skip) begin
      alu_o.pc = alu_i.pc + 16'd2;
    end

    // VF lives in its own register; the array only takes V0..VE
    alu_o.gp_we    = (wr || flagged) && (alu_i.reg_x != FLAG_REG);
    alu_o.gp_wdata = flagged ? res : wval;
    alu_o.vf_we    = flagged || (wr && (alu_i.reg_x == FLAG_REG));
    alu_o.vf_wdata = flagged ? {7'h00, flag} : wval;

    alu_o.flag_value = alu_o.vf_we ? alu_o.vf_wdata : alu_i.vf;
    if (alu_i.reg_x == FLAG_REG) begin
      alu_o.dest_value = alu_o.flag_value;
    end else begin
      alu_o.dest_value = alu_o.gp_we ? alu_o.gp_wdata : alu_i.vx;
    end
  end

endmodule

// File: sv/chip8_register_execute_unit_core.sv
// ----------------------------------------------------------------------------
// chip8_register_execute_unit_core - CHIP-8 register execute unit
// Executes one decoded CHIP-8 operation per transaction and reports the
// resulting machine state.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one decoded operation per transaction, taken when
//   in_valid and in_ready are both high at a rising edge of clk.
//   Result channel (out_*): exactly one result per operation, in order,
//   holding PC, I, Vx, VF, both timers and a status code.
// Pipeline: the operation is registered at acceptance together with Vx and
//   Vy read from the register file; the edge that executes it updates all
//   state and loads the result register, once the result side is free.
// Throughput: one operation per cycle without a stall. Register file reads
//   at acceptance are forwarded from the write of the operation executing in
//   that cycle; the stack top is held in a register, next entry prefetched.
// Stall: when out_ready is low the result register holds, the operation in
//   the input register waits, and in_ready drops once both are full.
// Reset (rst_n low, synchronous): registers, PC, I, timers and the stack
//   level clear; both stages empty. No clearing pass is needed: the
//   register file uses per-entry valid bits and the stack is read only
//   where a call wrote it.
// ----------------------------------------------------------------------------
module chip8_register_execute_unit_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [4:0]  in_mode,
  input  logic [3:0]  in_reg_x,
  input  logic [3:0]  in_reg_y,
  input  logic [7:0]  in_imm_byte,
  input  logic [11:0] in_target_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_pc_out,
  output logic [15:0] out_index_out,
  output logic [7:0]  out_dest_value,
  output logic [7:0]  out_flag_value,
  output logic [7:0]  out_delay_out,
  output logic [7:0]  out_sound_out,
  output logic [1:0]  out_status
);
  import c8eu_pkg::*;

  // handshake
  logic in_fire;
  logic exec_fire;

  // input (operand) stage
  logic                 s1_valid_r;
  logic [4:0]           s1_mode_r;
  logic [REG_IDX_W-1:0] s1_reg_x_r;
  logic [7:0]           s1_imm_r;
  logic [11:0]          s1_addr_r;
  logic [7:0]           s1_vx_r;
  logic [7:0]           s1_vy_r;

  // architectural state
  logic [7:0]           gp_mem [REG_COUNT];
  logic [REG_COUNT-1:0] gp_vld_r;
  logic [7:0]           v0_r;
  logic [7:0]           vf_r;
  logic [7:0]           vf_nxt;
  logic [15:0]          pc_r;
  logic [15:0]          index_r;
  logic [7:0]           delay_r;
  logic [7:0]           sound_r;

  // return stack: top held in tos_r, entry below it prefetched in stk_rd_r
  logic [15:0]            stk_mem [STACK_ENTRIES];
  logic [LEVEL_W-1:0]     level_r;
  logic [LEVEL_W-1:0]     level_nxt;
  logic [LEVEL_W-1:0]     below_lvl;
  logic [STACK_IDX_W-1:0] stk_raddr;
  logic [15:0]            tos_r;
  logic [15:0]            stk_rd_r;

  // result register
  logic        out_valid_r;
  logic [15:0] out_pc_r;
  logic [15:0] out_index_r;
  logic [7:0]  out_dest_r;
  logic [7:0]  out_flag_r;
  logic [7:0]  out_delay_r;
  logic [7:0]  out_sound_r;
  logic [1:0]  out_status_r;

  alu_in_t  alu_in;
  alu_out_t alu_out;

  assign exec_fire = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || exec_fire;
  assign in_fire   = in_valid && in_ready;

  // ---------------------------------------------------------------- execute
  always_comb begin
    alu_in.mode  = s1_mode_r;
    alu_in.reg_x = s1_reg_x_r;
    alu_in.imm   = s1_imm_r;
    alu_in.addr  = s1_addr_r;
    alu_in.vx    = s1_vx_r;
    alu_in.vy    = s1_vy_r;
    alu_in.v0    = v0_r;
    alu_in.vf    = vf_r;
    alu_in.pc    = pc_r;
    alu_in.index = index_r;
    alu_in.delay = delay_r;
    alu_in.sound = sound_r;
    alu_in.level = level_r;
    alu_in.tos   = tos_r;
  end

  c8eu_alu u_alu (
    .alu_i (alu_in),
    .alu_o (alu_out)
  );

  // VF as seen by an operand read at the same edge as the execute write
  assign vf_nxt = (exec_fire && alu_out.vf_we) ? alu_out.vf_wdata : vf_r;

  // -------------------------------------------------------- operand stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (exec_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  // register file read at acceptance, bypassing the write of this cycle
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r  <= in_mode;
      s1_reg_x_r <= in_reg_x;
      s1_imm_r   <= in_imm_byte;
      s1_addr_r  <= in_target_addr;
      if (in_reg_x == FLAG_REG) begin
        s1_vx_r <= vf_nxt;
      end else if (exec_fire && alu_out.gp_we && (s1_reg_x_r == in_reg_x)) begin
        s1_vx_r <= alu_out.gp_wdata;
      end else if (!gp_vld_r[in_reg_x]) begin
        s1_vx_r <= 8'h00;
      end else begin
        s1_vx_r <= gp_mem[in_reg_x];
      end
      if (in_reg_y == FLAG_REG) begin
        s1_vy_r <= vf_nxt;
      end else if (exec_fire && alu_out.gp_we && (s1_reg_x_r == in_reg_y)) begin
        s1_vy_r <= alu_out.gp_wdata;
      end else if (!gp_vld_r[in_reg_y]) begin
        s1_vy_r <= 8'h00;
      end else begin
        s1_vy_r <= gp_mem[in_reg_y];
      end
    end
  end

  // ------------------------------------------------------- register file
  always_ff @(posedge clk) begin
    if (exec_fire && alu_out.gp_we) begin
      gp_mem[s1_reg_x_r] <= alu_out.gp_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gp_vld_r <= '0;
      v0_r     <= 8'h00;
      vf_r     <= 8'h00;
      pc_r     <= 16'h0000;
      index_r  <= 16'h0000;
      delay_r  <= 8'h00;
      sound_r  <= 8'h00;
    end else if (exec_fire) begin
      if (alu_out.gp_we) begin
        gp_vld_r[s1_reg_x_r] <= 1'b1;
        if (s1_reg_x_r == '0) begin
          v0_r <= alu_out.gp_wdata;
        end
      end
      vf_r    <= vf_nxt;
      pc_r    <= alu_out.pc;
      index_r <= alu_out.index;
      delay_r <= alu_out.delay;
      sound_r <= alu_out.sound;
    end
  end

  // ---------------------------------------------------------- return stack
  always_comb begin
    level_nxt = level_r;
    if (exec_fire && alu_out.push) begin
      level_nxt = level_r + LEVEL_W'(1);
    end else if (exec_fire && alu_out.pop) begin
      level_nxt = level_r - LEVEL_W'(1);
    end
  end

  // prefetch the entry below the next top; never the slot written this edge
  assign below_lvl = level_nxt - LEVEL_W'(2);
  assign stk_raddr = below_lvl[STACK_IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (exec_fire && alu_out.push) begin
      stk_mem[level_r[STACK_IDX_W-1:0]] <= pc_r;
    end
    stk_rd_r <= stk_mem[stk_raddr];
  end

  always_ff @(posedge clk) begin
    if (exec_fire && alu_out.push) begin
      tos_r <= pc_r;
    end else if (exec_fire && alu_out.pop) begin
      tos_r <= stk_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
    end else begin
      level_r <= level_nxt;
    end
  end

  // ------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_pc_r     <= alu_out.pc;
      out_index_r  <= alu_out.index;
      out_dest_r   <= alu_out.dest_value;
      out_flag_r   <= alu_out.flag_value;
      out_delay_r  <= alu_out.delay;
      out_sound_r  <= alu_out.sound;
      out_status_r <= alu_out.status;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pc_out     = out_pc_r;
  assign out_index_out  = out_index_r;
  assign out_dest_value = out_dest_r;
  assign out_flag_value = out_flag_r;
  assign out_delay_out  = out_delay_r;
  assign out_sound_out  = out_sound_r;
  assign out_status     = out_status_r;

endmodule

// File: sv/c8eu_checker.sv
// ----------------------------------------------------------------------------
// c8eu_checker - port-level checks for the CHIP-8 register execute unit
// Watches the top-level channels for ordering, stall and reset behavior.
// ----------------------------------------------------------------------------
module c8eu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_pc_out,
  input logic [15:0] out_index_out,
  input logic [7:0]  out_dest_value,
  input logic [7:0]  out_flag_value,
  input logic [7:0]  out_delay_out,
  input logic [7:0]  out_sound_out,
  input logic [1:0]  out_status
);
  import c8eu_pkg::*;

  // a stalled result transaction stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pc_out) &&
      $stable(out_index_out) && $stable(out_dest_value) &&
      $stable(out_flag_value) && $stable(out_delay_out) &&
      $stable(out_sound_out) && $stable(out_status))
    else $error("result changed while stalled");

  // an accepted operation leads to out_valid via the operand and result registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> ##1 out_valid)
    else $error("accepted operation produced no result");

  // input side only backs up when the result side is full
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty result register");

  // reset empties both stages
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_OVERFLOW ||
      out_status == ST_UNDERFLOW))
    else $error("illegal status code");

endmodule

bind chip8_register_execute_unit_core c8eu_checker u_c8eu_checker (.*);
